// ===== rtl/core/itoad_pkg.sv =====
// ============================================================================
// itoad_pkg
// Shared types, constants and helpers for the integer to ASCII converter.
// ============================================================================
package itoad_pkg;

    localparam int DIGIT_SLOTS = 11;
    localparam int CNT_W       = $clog2(DIGIT_SLOTS + 1);
    localparam int VAL_W       = 32;

    localparam logic [31:0] RECIP10   = 32'hCCCC_CCCD;
    localparam int          RECIP_SHR = 35;

    localparam logic [7:0] CHAR_ZERO  = 8'h30;
    localparam logic [7:0] CHAR_A     = 8'h61;
    localparam logic [7:0] CHAR_MINUS = 8'h2D;

    typedef enum logic [1:0] {
        MODE_UDEC = 2'd0,
        MODE_SDEC = 2'd1,
        MODE_HEX  = 2'd2,
        MODE_RSVD = 2'd3
    } t_mode;

    typedef enum logic [1:0] {
        S_IDLE = 2'd0,
        S_DIV  = 2'd1,
        S_SIGN = 2'd2,
        S_EMIT = 2'd3
    } t_state;

    typedef struct packed {
        logic load;
        logic step;
        logic put_sign;
        logic put_digit;
    } t_dp_cmd;

    typedef struct packed {
        logic             q_zero;
        logic             slots_full;
        logic             cnt_one;
        logic             neg;
        logic             out_free;
        logic [CNT_W-1:0] cnt;
    } t_dp_status;

    function automatic logic [7:0] glyph(input logic [3:0] digit);
        logic [7:0] ch;
        if (digit < 4'd10) begin
            ch = CHAR_ZERO + {4'b0, digit};
        end else begin
            ch = CHAR_A + {4'b0, digit} - 8'd10;
        end
        return ch;
    endfunction

endpackage

// ===== rtl/core/itoad_if.sv =====
// ============================================================================
// itoad_if
// Valid/ready channel interfaces for number words and character words.
// ============================================================================
interface itoad_in_if;
    logic        valid;
    logic        ready;
    logic [1:0]  command;
    logic [31:0] value;

    modport source (output valid, output command, output value, input ready);
    modport sink   (input valid, input command, input value, output ready);
endinterface

interface itoad_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] character;
    logic       last;

    modport source (output valid, output character, output last, input ready);
    modport sink   (input valid, input character, input last, output ready);
endinterface

// ===== rtl/core/itoad_dp.sv =====
// ============================================================================
// itoad_dp
// Datapath: value register, divide step, digit stack and output register.
// ============================================================================
module itoad_dp (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  itoad_pkg::t_dp_cmd     i_cmd,
    output itoad_pkg::t_dp_status  o_st,
    input  logic [1:0]             i_command,
    input  logic [31:0]            i_value,
    output logic                   o_valid,
    input  logic                   i_ready,
    output logic [7:0]             o_character,
    output logic                   o_last
);
    import itoad_pkg::*;

    logic [VAL_W-1:0] r_val, n_val;
    logic             r_hex;
    logic             r_neg;
    logic [CNT_W-1:0] r_cnt;
    logic [3:0]       r_slot [DIGIT_SLOTS];
    logic             r_out_valid;
    logic [7:0]       r_out_char;
    logic             r_out_last;

    logic [63:0]      prod;
    logic [VAL_W-1:0] q10;
    logic [VAL_W-1:0] rem10;
    logic [VAL_W-1:0] q;
    logic [3:0]       digit;
    logic             neg_in;

    assign prod  = {32'b0, r_val} * {32'b0, RECIP10};
    assign q10   = VAL_W'(prod >> RECIP_SHR);
    assign rem10 = r_val - (q10 << 3) - (q10 << 1);
    assign q     = r_hex ? (r_val >> 4) : q10;
    assign digit = r_hex ? r_val[3:0] : rem10[3:0];
    assign n_val = q;

    assign neg_in = (t_mode'(i_command) == MODE_SDEC) && i_value[VAL_W-1];

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_val <= neg_in ? (~i_value + VAL_W'(1)) : i_value;
            r_hex <= (t_mode'(i_command) == MODE_HEX);
            r_neg <= neg_in;
        end else if (i_cmd.step) begin
            r_val <= n_val;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= '0;
        end else if (i_cmd.load) begin
            r_cnt <= '0;
        end else if (i_cmd.step) begin
            r_cnt <= r_cnt + CNT_W'(1);
        end else if (i_cmd.put_digit) begin
            r_cnt <= r_cnt - CNT_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.step) begin
            r_slot[0] <= digit;
            for (int i = 1; i < DIGIT_SLOTS; i++) begin
                r_slot[i] <= r_slot[i-1];
            end
        end else if (i_cmd.put_digit) begin
            for (int i = 0; i < DIGIT_SLOTS - 1; i++) begin
                r_slot[i] <= r_slot[i+1];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.put_sign || i_cmd.put_digit) begin
            r_out_valid <= 1'b1;
        end else if (i_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.put_sign) begin
            r_out_char <= CHAR_MINUS;
            r_out_last <= 1'b0;
        end else if (i_cmd.put_digit) begin
            r_out_char <= glyph(r_slot[0]);
            r_out_last <= (r_cnt == CNT_W'(1));
        end
    end

    assign o_st.q_zero     = (q == '0);
    assign o_st.slots_full = (r_cnt == CNT_W'(DIGIT_SLOTS - 1));
    assign o_st.cnt_one    = (r_cnt == CNT_W'(1));
    assign o_st.neg        = r_neg;
    assign o_st.out_free   = !r_out_valid || i_ready;
    assign o_st.cnt        = r_cnt;

    assign o_valid     = r_out_valid;
    assign o_character = r_out_char;
    assign o_last      = r_out_last;

endmodule

// ===== rtl/core/itoad_ctrl.sv =====
// ============================================================================
// itoad_ctrl
// Controller: sequences load, divide steps, sign and digit output.
// ============================================================================
module itoad_ctrl (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_in_valid,
    output logic                   o_in_ready,
    input  itoad_pkg::t_dp_status  i_st,
    output itoad_pkg::t_dp_cmd     o_cmd,
    output itoad_pkg::t_state      o_state
);
    import itoad_pkg::*;

    t_state r_state, n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state    = r_state;
        o_cmd      = '0;
        o_in_ready = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.load = 1'b1;
                    n_state    = S_DIV;
                end
            end
            S_DIV: begin
                o_cmd.step = 1'b1;
                if (i_st.q_zero || i_st.slots_full) begin
                    n_state = i_st.neg ? S_SIGN : S_EMIT;
                end
            end
            S_SIGN: begin
                if (i_st.out_free) begin
                    o_cmd.put_sign = 1'b1;
                    n_state        = S_EMIT;
                end
            end
            S_EMIT: begin
                if (i_st.out_free) begin
                    o_cmd.put_digit = 1'b1;
                    if (i_st.cnt_one) begin
                        n_state = S_IDLE;
                    end
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    assign o_state = r_state;

endmodule

// ===== rtl/core/integer_to_ascii_digits.sv =====
// ============================================================================
// integer_to_ascii_digits
// Converts a 32-bit number into ASCII decimal or hexadecimal characters.
// ============================================================================
// The input channel takes one word with a mode and a 32-bit value. Mode 0 is
// unsigned decimal, mode 1 signed decimal, mode 2 lower-case hexadecimal, and
// mode 3 behaves as unsigned decimal. The output channel gives one character
// word per cycle at best, most significant digit first, with last set on the
// final character of the number.
// After a word is accepted, the divide unit produces one digit per cycle,
// least significant first, into a digit stack (a constant multiply by the
// reciprocal of ten, or a four-bit shift in hexadecimal mode). The stack is
// then unloaded through the output register, preceded by a minus sign for a
// negative signed value. The next word is accepted once the last character
// has entered the output register.
// When the receiver stalls, the output register holds its word and the
// controller waits. Reset is synchronous and returns the block to idle with
// no output pending.
// ============================================================================
module integer_to_ascii_digits (
    input  logic        i_clk,
    input  logic        i_rst_n,
    itoad_in_if.sink    i_in,
    itoad_out_if.source o_out
);
    import itoad_pkg::*;

    t_dp_cmd    cmd;
    t_dp_status st;
    t_state     state;

    itoad_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in.valid),
        .o_in_ready (i_in.ready),
        .i_st       (st),
        .o_cmd      (cmd),
        .o_state    (state)
    );

    itoad_dp u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (cmd),
        .o_st        (st),
        .i_command   (i_in.command),
        .i_value     (i_in.value),
        .o_valid     (o_out.valid),
        .i_ready     (o_out.ready),
        .o_character (o_out.character),
        .o_last      (o_out.last)
    );

    a_idle_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (state == S_IDLE) |-> (st.cnt == '0))
        else $error("digit stack not empty while idle");

    a_accept_div: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in.valid && i_in.ready) |=> (state == S_DIV))
        else $error("accepted word did not start dividing");

    a_last_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (cmd.put_digit && st.cnt_one) |=> (state == S_IDLE && o_out.last))
        else $error("final digit did not end the run");

    a_cnt_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        st.cnt <= CNT_W'(DIGIT_SLOTS))
        else $error("digit count out of range");

endmodule

// ===== tb/ascii_digit_checker.sv =====
// ============================================================================
// ascii_digit_checker
// Predicts and checks the character words of the integer to ASCII converter.
// ============================================================================
// Every accepted number word is spelled out into the characters it must give.
// Those characters are queued in order. Every accepted character word is
// compared with the oldest queued character, on both the character and the
// last flag. A character word that arrives when nothing is queued is an
// error. The error count and the number of characters still queued go to
// the top.
// ============================================================================
module ascii_digit_checker (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    input  logic        i_in_ready,
    input  logic [1:0]  i_in_command,
    input  logic [31:0] i_in_value,
    input  logic        i_out_valid,
    input  logic        i_out_ready,
    input  logic [7:0]  i_out_character,
    input  logic        i_out_last,
    output int          o_fail_count,
    output int          o_pending
);
    import itoad_pkg::*;

    localparam int          MAX_REPORTS = 10;
    localparam logic [127:0] GLYPHS     = "0123456789abcdef";

    typedef struct packed {
        logic [7:0] character;
        logic       last;
    } t_char_word;

    t_char_word  expected_chars[$];
    int          mismatches;
    int unsigned chars_seen;

    function automatic void push_char(input logic [7:0] character, input logic last);
        t_char_word word;
        word.character = character;
        word.last      = last;
        expected_chars.push_back(word);
    endfunction

    function automatic void spell_number(input t_mode mode, input logic [31:0] value);
        logic [31:0] magnitude;
        logic [31:0] radix;
        logic [7:0]  digits [DIGIT_SLOTS];
        int          count;
        int          digit;
        magnitude = value;
        radix     = (mode == MODE_HEX) ? 32'd16 : 32'd10;
        count     = 0;
        if (mode == MODE_SDEC && value[31]) begin
            push_char(CHAR_MINUS, 1'b0);
            magnitude = -value;
        end
        if (magnitude == 32'd0) begin
            push_char(CHAR_ZERO, 1'b1);
        end else begin
            while (magnitude != 32'd0 && count < DIGIT_SLOTS) begin
                digit         = int'(magnitude % radix);
                digits[count] = GLYPHS[(15 - digit) * 8 +: 8];
                magnitude     = magnitude / radix;
                count++;
            end
            for (int i = count - 1; i >= 0; i--) begin
                push_char(digits[i], i == 0);
            end
        end
    endfunction

    always @(posedge i_clk) begin
        t_char_word got;
        t_char_word want;
        if (!i_rst_n) begin
            expected_chars.delete();
            mismatches = 0;
            chars_seen = 0;
        end else begin
            if (i_in_valid && i_in_ready) begin
                spell_number(t_mode'(i_in_command), i_in_value);
            end
            if (i_out_valid && i_out_ready) begin
                got.character = i_out_character;
                got.last      = i_out_last;
                if (expected_chars.size() == 0) begin
                    if (mismatches < MAX_REPORTS) begin
                        $display("char %0d: unexpected word character %h last %b",
                                 chars_seen, got.character, got.last);
                    end
                    mismatches++;
                end else begin
                    want = expected_chars.pop_front();
                    if (got.character !== want.character || got.last !== want.last) begin
                        if (mismatches < MAX_REPORTS) begin
                            $display("char %0d: character exp %h got %h, last exp %b got %b",
                                     chars_seen, want.character, got.character,
                                     want.last, got.last);
                        end
                        mismatches++;
                    end
                end
                chars_seen++;
            end
        end
        o_fail_count <= mismatches;
        o_pending    <= expected_chars.size();
    end

endmodule

// ===== tb/tb_integer_to_ascii_digits.sv =====
// ============================================================================
// tb_integer_to_ascii_digits
// Testbench top for the integer to ASCII converter.
// ============================================================================
// Sends a directed set of corner numbers in every mode, then random numbers
// of all lengths in three idle profiles. The receiver stalls at random, and
// once holds off for a long stretch while the sender keeps pushing. The
// checker beside the block predicts and compares every character word.
// ============================================================================
module tb_integer_to_ascii_digits;
    import itoad_pkg::*;

    localparam int DRAIN_CYCLES     = 40;
    localparam int HOLD_CYCLES      = 400;
    localparam int RANDOM_PER_PHASE = 130;

    logic        i_clk;
    logic        i_rst_n;
    int unsigned send_idle_pct;
    int unsigned recv_idle_pct;
    int unsigned hold_requests;
    int          fail_count;
    int          pending_chars;

    itoad_in_if  number_ch ();
    itoad_out_if char_ch ();

    integer_to_ascii_digits dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (number_ch),
        .o_out   (char_ch)
    );

    ascii_digit_checker u_checker (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_in_valid      (number_ch.valid),
        .i_in_ready      (number_ch.ready),
        .i_in_command    (number_ch.command),
        .i_in_value      (number_ch.value),
        .i_out_valid     (char_ch.valid),
        .i_out_ready     (char_ch.ready),
        .i_out_character (char_ch.character),
        .i_out_last      (char_ch.last),
        .o_fail_count    (fail_count),
        .o_pending       (pending_chars)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    initial begin
        #3_000_000;
        $display("*** FAILED ***");
        $finish;
    end

    initial begin
        int unsigned holds_done;
        holds_done = 0;
        char_ch.ready <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (holds_done < hold_requests) begin
                holds_done++;
                char_ch.ready <= 1'b0;
                repeat (HOLD_CYCLES - 1) @(posedge i_clk);
            end else begin
                char_ch.ready <= ($urandom_range(99, 0) >= recv_idle_pct);
            end
        end
    end

    task automatic offer_number(input t_mode mode, input logic [31:0] value);
        while ($urandom_range(99, 0) < send_idle_pct) begin
            number_ch.valid <= 1'b0;
            @(posedge i_clk);
        end
        number_ch.valid   <= 1'b1;
        number_ch.command <= mode;
        number_ch.value   <= value;
        @(posedge i_clk);
        while (!number_ch.ready) @(posedge i_clk);
    endtask

    task automatic drain_results;
        number_ch.valid <= 1'b0;
        @(posedge i_clk);
        while (pending_chars != 0) @(posedge i_clk);
    endtask

    task automatic send_random_numbers(input int count);
        int unsigned pick;
        t_mode       mode;
        logic [31:0] value;
        repeat (count) begin
            pick  = $urandom_range(99, 0);
            mode  = (pick < 6) ? MODE_RSVD : t_mode'($urandom_range(2, 0));
            value = $urandom >> $urandom_range(31, 0);
            if (pick >= 6 && pick < 16) begin
                value = 32'd10 ** $urandom_range(9, 0) - $urandom_range(1, 0);
            end else if (pick >= 16 && pick < 20) begin
                value = 32'h8000_0000 + $urandom_range(1, 0) - $urandom_range(1, 0);
            end
            if (mode == MODE_SDEC && $urandom_range(1, 0) == 1) begin
                value = -value;
            end
            offer_number(mode, value);
        end
    endtask

    initial begin
        logic [31:0] corner_values [5];
        corner_values = '{32'd0, 32'd1, 32'h7FFF_FFFF, 32'h8000_0000, 32'hFFFF_FFFF};
        number_ch.valid   <= 1'b0;
        number_ch.command <= MODE_UDEC;
        number_ch.value   <= 32'd0;
        send_idle_pct     <= 27;
        recv_idle_pct     <= 68;
        hold_requests     <= 0;
        i_rst_n           <= 1'b0;
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        for (int m = 0; m < 3; m++) begin
            foreach (corner_values[i]) begin
                offer_number(t_mode'(m), corner_values[i]);
            end
        end
        offer_number(MODE_RSVD, 32'hFFFF_FFFF);
        offer_number(MODE_RSVD, 32'd0);
        offer_number(MODE_UDEC, 32'd999_999_999);
        offer_number(MODE_UDEC, 32'd1_000_000_000);
        offer_number(MODE_SDEC, 32'hFFFF_FFF6);
        offer_number(MODE_HEX, 32'h0000_000F);
        offer_number(MODE_HEX, 32'h0000_0010);
        drain_results();

        send_random_numbers(RANDOM_PER_PHASE);
        drain_results();

        send_idle_pct <= 68;
        recv_idle_pct <= 27;
        send_random_numbers(RANDOM_PER_PHASE);
        drain_results();

        send_idle_pct <= 0;
        recv_idle_pct <= 0;
        hold_requests <= 1;
        send_random_numbers(RANDOM_PER_PHASE);
        drain_results();

        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (fail_count == 0 && pending_chars == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end

endmodule
